[hw/rtl/pwds_pkg.sv]
// Shared types and constants of the periodic within-distance search.
package pwds_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_CELL_X = 2'd0;
    localparam logic [1:0] REG_CELL_Y = 2'd1;
    localparam logic [1:0] REG_CELL_Z = 2'd2;
    localparam logic [1:0] REG_CUTOFF = 2'd3;

    // Request types.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;

    // Field widths.
    localparam int REG_W   = 31;
    localparam int COORD_W = 32;
    localparam int TAG_W   = 20;

    // Reset values of the configuration registers.
    localparam logic [REG_W-1:0] CELL_RESET   = 31'd6553600;
    localparam logic [REG_W-1:0] CUTOFF_RESET = 31'd327680;

    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

[hw/rtl/pwds_ram.sv]
// Generic single-port-write, registered-read RAM.
module pwds_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/periodic_within_distance_search.sv]
// Top level: reference store and minimum-image cutoff search over it.
// A query on an empty store answers with no match; otherwise each stored reference walked
// takes one RAM read, then per axis a load state and, on a periodic axis, a 32-step restoring
// remainder on the shared divider, then the squares on the shared multiplier; an axis beyond
// the cutoff ends that reference early.
// Throughput: one item at a time; the search stops at the first matching reference.
// Reset (synchronous, active low) empties the store, clears the overflow flag and restores the
// register defaults; the store contents are left as they are.
module periodic_within_distance_search
    import pwds_pkg::*;
#(
    parameter int MAX_REFS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration write port.
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [REG_W-1:0]    cfg_data,
    // Request channel.
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic                s_first_ref,
    input  logic [TAG_W-1:0]    s_atom_id,
    input  logic [COORD_W-1:0]  s_pos_x,
    input  logic [COORD_W-1:0]  s_pos_y,
    input  logic [COORD_W-1:0]  s_pos_z,
    // Result channel.
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TAG_W-1:0]    m_query_tag,
    output logic                m_within_res,
    output logic                m_refs_dropped
);

    localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CW = $clog2(MAX_REFS + 1);
    localparam int RW = 3 * COORD_W;

    // Configuration registers.
    logic [REG_W-1:0] cell_x_reg, cell_y_reg, cell_z_reg, cutoff_reg;

    // Control state.
    logic [2:0]       state_reg;
    logic [CW-1:0]    count_reg;
    logic             overflow_reg;
    logic [CW-1:0]    k_reg;
    logic [1:0]       axis_reg;
    logic [4:0]       bit_reg;
    logic [2:0]       step_reg;
    logic             m_valid_reg;

    // Datapath registers.
    coord_t           q_x_reg, q_y_reg, q_z_reg;
    logic [TAG_W-1:0] q_tag_reg;
    logic [31:0]      dvd_reg;
    logic [REG_W-1:0] rem_reg;
    logic [REG_W-1:0] mag_reg [3];
    logic [61:0]      prod_reg;
    logic [63:0]      acc_reg;
    logic [TAG_W-1:0] tag_out_reg;
    logic             within_out_reg;
    logic             dropped_out_reg;

    // RAM signals.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RW-1:0]    ram_rdata;

    logic             accept;
    logic             is_load;
    logic             store_full;

    assign s_ready    = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept     = s_valid && s_ready;
    assign is_load    = (s_req_type == REQ_LOAD);
    assign store_full = (count_reg == CW'(MAX_REFS));

    assign m_valid        = m_valid_reg;
    assign m_query_tag    = tag_out_reg;
    assign m_within_res   = within_out_reg;
    assign m_refs_dropped = dropped_out_reg;

    // Loads write at the fill position, or at the bottom on a restart.
    assign ram_we    = accept && is_load && (s_first_ref || !store_full);
    assign ram_waddr = s_first_ref ? '0 : count_reg[AW-1:0];

    pwds_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_REFS)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_pos_z, s_pos_y, s_pos_x}),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Per-axis operand selection.
    logic [COORD_W-1:0] ref_sel, pos_sel;
    logic [REG_W-1:0]   len_sel;
    always_comb begin
        case (axis_reg)
            2'd0: begin
                ref_sel = ram_rdata[COORD_W-1:0];
                pos_sel = q_x_reg;
                len_sel = cell_x_reg;
            end
            2'd1: begin
                ref_sel = ram_rdata[2*COORD_W-1:COORD_W];
                pos_sel = q_y_reg;
                len_sel = cell_y_reg;
            end
            default: begin
                ref_sel = ram_rdata[RW-1:2*COORD_W];
                pos_sel = q_z_reg;
                len_sel = cell_z_reg;
            end
        endcase
    end

    // Separation magnitude on the selected axis.
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        diff_neg;
    logic [31:0]             sep_mag;
    assign diff     = $signed({pos_sel[COORD_W-1], pos_sel})
                    - $signed({ref_sel[COORD_W-1], ref_sel});
    assign diff_neg = -diff;
    assign sep_mag  = diff[COORD_W] ? diff_neg[31:0] : diff[31:0];

    // One restoring remainder step of the shared divider.
    logic [31:0]      trial;
    logic [REG_W-1:0] rem_step;
    logic [REG_W-1:0] len_minus_rem;
    assign trial    = {rem_reg, dvd_reg[31]};
    assign rem_step = (trial >= {1'b0, len_sel}) ? REG_W'(trial - {1'b0, len_sel})
                                                 : trial[REG_W-1:0];
    assign len_minus_rem = len_sel - rem_step;

    // Finished axis magnitude: raw on a non-periodic axis, else the nearer image.
    logic        fin_valid;
    logic [31:0] fin_mag;
    always_comb begin
        fin_valid = 1'b0;
        fin_mag   = sep_mag;
        if ((state_reg == ST_LOAD) && (len_sel == '0)) begin
            fin_valid = 1'b1;
        end else if ((state_reg == ST_DIV) && (bit_reg == 5'd0)) begin
            fin_valid = 1'b1;
            fin_mag   = ({rem_step, 1'b0} < {1'b0, len_sel}) ? {1'b0, rem_step}
                                                              : {1'b0, len_minus_rem};
        end
    end

    // Shared squarer operand.
    logic [REG_W-1:0] sq_op;
    assign sq_op = (step_reg < 3'd3) ? mag_reg[step_reg[1:0]] : cutoff_reg;

    logic last_ref;
    assign last_ref = ((k_reg + 1'b1) == count_reg);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_x_reg <= CELL_RESET;
            cell_y_reg <= CELL_RESET;
            cell_z_reg <= CELL_RESET;
            cutoff_reg <= CUTOFF_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_CELL_X: cell_x_reg <= cfg_data;
                REG_CELL_Y: cell_y_reg <= cfg_data;
                REG_CELL_Z: cell_z_reg <= cfg_data;
                REG_CUTOFF: cutoff_reg <= cfg_data;
                default:    cutoff_reg <= cutoff_reg;
            endcase
        end
    end

    // Sequencer and datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            k_reg        <= '0;
            axis_reg     <= '0;
            bit_reg      <= '0;
            step_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && is_load) begin
                        if (s_first_ref) begin
                            count_reg    <= CW'(1);
                            overflow_reg <= 1'b0;
                        end else if (store_full) begin
                            overflow_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end else if (accept) begin
                        q_x_reg   <= s_pos_x;
                        q_y_reg   <= s_pos_y;
                        q_z_reg   <= s_pos_z;
                        q_tag_reg <= s_atom_id;
                        k_reg     <= '0;
                        if (count_reg == '0) begin
                            m_valid_reg     <= 1'b1;
                            tag_out_reg     <= s_atom_id;
                            within_out_reg  <= 1'b0;
                            dropped_out_reg <= overflow_reg;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    axis_reg  <= '0;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    dvd_reg <= sep_mag;
                    rem_reg <= '0;
                    bit_reg <= 5'd31;
                    if (len_sel != '0) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_step;
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                    bit_reg <= bit_reg - 1'b1;
                end
                ST_MUL: begin
                    prod_reg <= sq_op * sq_op;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd0) begin
                        acc_reg <= '0;
                    end else if (step_reg < 3'd4) begin
                        acc_reg <= acc_reg + {2'b00, prod_reg};
                    end else begin
                        // Compare the squared distance against the squared cutoff.
                        if (acc_reg <= {2'b00, prod_reg}) begin
                            m_valid_reg     <= 1'b1;
                            tag_out_reg     <= q_tag_reg;
                            within_out_reg  <= 1'b1;
                            dropped_out_reg <= overflow_reg;
                            state_reg       <= ST_IDLE;
                        end else if (last_ref) begin
                            m_valid_reg     <= 1'b1;
                            tag_out_reg     <= q_tag_reg;
                            within_out_reg  <= 1'b0;
                            dropped_out_reg <= overflow_reg;
                            state_reg       <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // A finished axis either rejects the reference or moves on.
            if (fin_valid) begin
                if (fin_mag > {1'b0, cutoff_reg}) begin
                    if (last_ref) begin
                        m_valid_reg     <= 1'b1;
                        tag_out_reg     <= q_tag_reg;
                        within_out_reg  <= 1'b0;
                        dropped_out_reg <= overflow_reg;
                        state_reg       <= ST_IDLE;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end else begin
                    mag_reg[axis_reg] <= fin_mag[REG_W-1:0];
                    if (axis_reg == 2'd2) begin
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end else begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_LOAD;
                    end
                end
            end
        end
    end

    // The store never holds more references than its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CW'(MAX_REFS))
        else $error("reference count beyond capacity");

    // The remainder stays below the cell length while dividing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < len_sel))
        else $error("divider remainder out of range");

    // A query on an empty store answers at once with no match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_load && (count_reg == '0)) |=> (m_valid && !m_within_res))
        else $error("empty-store query not answered");

    // The search only walks stored references.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (k_reg < count_reg))
        else $error("search index beyond fill count");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the periodic within-distance search.
module testbench
    import pwds_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic         req_type;
        logic         first_ref;
        logic [19:0]  atom_id;
        coord_t       pos_x;
        coord_t       pos_y;
        coord_t       pos_z;
    } request_t;

    typedef struct {
        logic [19:0] tag;
        logic        hit;
        logic        dropped;
    } reply_t;

    // Scoreboard: keeps its own copy of the store and registers, predicts replies.
    class hit_scoreboard;
        logic [30:0] cell_len[3];
        logic [30:0] cutoff;
        coord_t      store_x[STORE_DEPTH];
        coord_t      store_y[STORE_DEPTH];
        coord_t      store_z[STORE_DEPTH];
        int          stored;
        bit          dropped_flag;
        reply_t      pending_replies[$];
        int          errors;

        function new();
            cell_len[0] = CELL_RESET;
            cell_len[1] = CELL_RESET;
            cell_len[2] = CELL_RESET;
            cutoff = CUTOFF_RESET;
            stored = 0;
            dropped_flag = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [30:0] value);
            case (idx)
                REG_CELL_X: cell_len[0] = value;
                REG_CELL_Y: cell_len[1] = value;
                REG_CELL_Z: cell_len[2] = value;
                REG_CUTOFF: cutoff = value;
                default: ;
            endcase
        endfunction

        // Magnitude of the minimum-image separation, rounding half away from zero.
        function longint unsigned image_dist(coord_t a, coord_t b, logic [30:0] len);
            longint d;
            longint unsigned m, q, ql, l;
            d = longint'(b) - longint'(a);
            m = (d < 0) ? -d : d;
            l = {33'd0, len};
            if (l == 0) return m;
            q = (2 * m + l) / (2 * l);
            ql = q * l;
            return (ql > m) ? ql - m : m - ql;
        endfunction

        function bit near(int k, request_t r);
            longint unsigned c, ax, ay, az;
            c = {33'd0, cutoff};
            ax = image_dist(store_x[k], r.pos_x, cell_len[0]);
            ay = image_dist(store_y[k], r.pos_y, cell_len[1]);
            az = image_dist(store_z[k], r.pos_z, cell_len[2]);
            if (ax > c || ay > c || az > c) return 0;
            return (ax * ax + ay * ay + az * az) <= c * c;
        endfunction

        function void note_request(request_t r);
            reply_t rep;
            if (r.req_type == REQ_LOAD) begin
                if (r.first_ref) begin
                    stored = 0;
                    dropped_flag = 0;
                end
                if (stored < STORE_DEPTH) begin
                    store_x[stored] = r.pos_x;
                    store_y[stored] = r.pos_y;
                    store_z[stored] = r.pos_z;
                    stored++;
                end else begin
                    dropped_flag = 1;
                end
                return;
            end
            rep.tag = r.atom_id;
            rep.hit = 0;
            rep.dropped = dropped_flag;
            for (int k = 0; k < stored; k++) begin
                if (near(k, r)) begin
                    rep.hit = 1;
                    break;
                end
            end
            pending_replies.push_back(rep);
        endfunction

        function void check_reply(logic [19:0] tag, logic hit, logic dropped);
            reply_t exp_rep;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply tag=%h within_res=%b dropped=%b",
                         $time, tag, hit, dropped);
                errors++;
                return;
            end
            exp_rep = pending_replies.pop_front();
            if (tag !== exp_rep.tag) begin
                $display("%0t: query_tag expected %h actual %h", $time, exp_rep.tag, tag);
                errors++;
            end
            if (hit !== exp_rep.hit) begin
                $display("%0t: within_res expected %b actual %b (tag %h)",
                         $time, exp_rep.hit, hit, exp_rep.tag);
                errors++;
            end
            if (dropped !== exp_rep.dropped) begin
                $display("%0t: refs_dropped expected %b actual %b (tag %h)",
                         $time, exp_rep.dropped, dropped, exp_rep.tag);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [REG_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    logic              s_first_ref;
    logic [TAG_W-1:0]  s_atom_id;
    logic [COORD_W-1:0] s_pos_x;
    logic [COORD_W-1:0] s_pos_y;
    logic [COORD_W-1:0] s_pos_z;
    logic              m_valid;
    logic              m_ready;
    logic [TAG_W-1:0]  m_query_tag;
    logic              m_within_res;
    logic              m_refs_dropped;

    hit_scoreboard sb;
    int   tx_idle;
    int   rx_idle;
    bit   hold_request;
    int   cycle_count;
    coord_t set_x[$], set_y[$], set_z[$];

    periodic_within_distance_search dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_first_ref(s_first_ref), .s_atom_id(s_atom_id),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_query_tag(m_query_tag),
        .m_within_res(m_within_res), .m_refs_dropped(m_refs_dropped)
    );

    // Clock.
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Result sampling.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_reply(m_query_tag, m_within_res, m_refs_dropped);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int hold;
        bit hold_taken;
        hold = 0;
        hold_taken = 0;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 0;
                hold--;
            end else if (hold_request && !hold_taken) begin
                hold_taken = 1;
                hold = 800;
                m_ready = 0;
            end else begin
                m_ready = ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // Present one item and wait until it is accepted.
    task automatic send_item(request_t r);
        if ($urandom_range(99) < tx_idle) begin
            s_valid = 0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_req_type  = r.req_type;
        s_first_ref = r.first_ref;
        s_atom_id   = r.atom_id;
        s_pos_x     = r.pos_x;
        s_pos_y     = r.pos_y;
        s_pos_z     = r.pos_z;
        s_valid     = 1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
        @(negedge aclk);
    endtask

    task automatic load_ref(bit restart, coord_t x, coord_t y, coord_t z);
        request_t r;
        r = '{REQ_LOAD, restart, 20'($urandom), x, y, z};
        send_item(r);
        if (restart) begin
            set_x.delete(); set_y.delete(); set_z.delete();
        end
        set_x.push_back(x); set_y.push_back(y); set_z.push_back(z);
    endtask

    task automatic query_at(coord_t x, coord_t y, coord_t z);
        request_t r;
        r = '{REQ_QUERY, 1'($urandom), 20'($urandom), x, y, z};
        send_item(r);
    endtask

    // Drain outstanding replies, then let a load finish before touching registers.
    task automatic wait_idle();
        s_valid = 0;
        while (sb.pending_replies.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] value);
        cfg_write = 1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_write = 0;
    endtask

    function automatic coord_t offset_coord(coord_t base, logic [30:0] len, logic [30:0] cut);
        longint span;
        int k;
        span = longint'(cut) + 2;
        if (span > 64'd100000000) span = 64'd100000000;
        k = int'($urandom_range(4)) - 2;
        return coord_t'(longint'(base) + k * longint'(len)
                        + longint'($urandom_range(2 * span)) - span);
    endfunction

    // Stimulus.
    initial begin : stimulus
        logic [30:0] cx, cy, cz, cut;
        int pick;
        sb = new();
        tx_idle = 0;
        rx_idle = 0;
        hold_request = 0;
        aresetn = 0;
        cfg_write = 0;
        cfg_index = REG_CELL_X;
        cfg_data = '0;
        s_valid = 0;
        s_req_type = REQ_LOAD;
        s_first_ref = 0;
        s_atom_id = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Directed part at the reset register values.
        query_at(0, 0, 0);                       // empty store
        load_ref(1, 0, 0, 0);
        query_at(0, 0, 0);                       // same spot
        query_at(327680, 0, 0);                  // exactly at the cutoff
        query_at(327681, 0, 0);                  // just past the cutoff
        query_at(6553600 - 100, 0, 100);         // across the cell boundary
        query_at(3276800, 0, 0);                 // half a cell, rounds away from zero
        query_at(-3276800, -6553600, 13107200);
        load_ref(0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        query_at(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        query_at(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        query_at(200000, 200000, 200000);        // inside on each axis, outside in 3D

        // Store full: loads past capacity are dropped and flagged.
        load_ref(1, 1000, 2000, 3000);
        for (int i = 1; i < STORE_DEPTH + 2; i++) begin
            load_ref(0, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        end
        query_at(1000, 2000, 3000);
        query_at(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        load_ref(1, 5, 5, 5);                    // restart clears the drop flag
        query_at(5, 5, 5);

        // Random part: phases of register settings and idling.
        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            case (ph)
                0: begin cx = 31'h7FFFFFFF; cy = 31'h7FFFFFFF; cz = 31'h7FFFFFFF;
                          cut = 31'h7FFFFFFF; end
                1: begin cx = 31'd1; cy = 31'd1; cz = 31'd1; cut = 31'd0; end
                2: begin cx = 31'd0; cy = 31'($urandom_range(1 << 20, 1 << 24));
                          cz = 31'($urandom_range(1 << 20, 1 << 24));
                          cut = 31'($urandom_range(1 << 14, 1 << 19)); end
                3: begin cx = 31'h7FFFFFFF; cy = 31'd1; cz = 31'd0; cut = 31'd1; end
                default: begin
                    cx = 31'($urandom_range(1 << 18, 1 << 25));
                    cy = 31'($urandom_range(1 << 18, 1 << 25));
                    cz = 31'($urandom_range(1 << 18, 1 << 25));
                    cut = 31'($urandom_range(1 << 12, 1 << 23));
                end
            endcase
            write_reg(REG_CELL_X, cx);
            write_reg(REG_CELL_Y, cy);
            write_reg(REG_CELL_Z, cz);
            write_reg(REG_CUTOFF, cut);
            tx_idle = (ph < 4) ? 16 : (ph < 7) ? 51 : 0;
            rx_idle = (ph < 4) ? 51 : (ph < 7) ? 16 : 0;
            if (ph == 4) hold_request = 1;

            for (int n = 0; n < 80; ) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    // Noise: stray loads and queries at random spots.
                    if (set_x.size() < 6 && pick < 6) begin
                        load_ref(0, coord_t'($urandom), coord_t'($urandom),
                                 coord_t'($urandom));
                    end else begin
                        query_at(coord_t'($urandom), coord_t'($urandom),
                                 coord_t'($urandom));
                    end
                    n++;
                end else begin
                    // A fresh small set followed by queries near its members.
                    int nref, nq, j;
                    nref = $urandom_range(1, 4);
                    for (int i = 0; i < nref; i++) begin
                        if ($urandom_range(3) == 0) begin
                            load_ref(i == 0, coord_t'($urandom), coord_t'($urandom),
                                     coord_t'($urandom));
                        end else begin
                            load_ref(i == 0, coord_t'($urandom_range(1 << 24)),
                                     -coord_t'($urandom_range(1 << 24)),
                                     coord_t'($urandom_range(1 << 24)));
                        end
                    end
                    nq = $urandom_range(1, 5);
                    for (int i = 0; i < nq; i++) begin
                        j = $urandom_range(set_x.size() - 1);
                        query_at(offset_coord(set_x[j], cx, cut),
                                 offset_coord(set_y[j], cy, cut),
                                 offset_coord(set_z[j], cz, cut));
                    end
                    n += nref + nq;
                end
            end
        end

        wait_idle();
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
